// ===== src/char_lcd_parallel_write_assert.svh =====
// ----------------------------------------------------------------------------
// char_lcd_parallel_write_assert.svh
// assertion macros shared by the lcd write block
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_PARALLEL_WRITE_ASSERT_SVH
`define CHAR_LCD_PARALLEL_WRITE_ASSERT_SVH

// same-cycle implication
`define CLPW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLPW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/clpw_pkg.sv =====
// ----------------------------------------------------------------------------
// clpw_pkg
// types, codes and helpers of the character lcd parallel write block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clpw_pkg;

  localparam logic [1:0] CMD_INSTR  = 2'd0;
  localparam logic [1:0] CMD_DATA   = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NIBBLE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_HOLD  = 2'd1;

  localparam logic [15:0] HOLD_RESET  = 16'd72;
  localparam int unsigned ROW_COUNT_DEF   = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CURSOR_SET = 8'h80;
  localparam logic [7:0] LO_MASK    = 8'h0F;
  localparam logic [7:0] HI_MASK    = 8'hF0;
  localparam logic [7:0] ADDR_MASK  = 8'h7F;

  localparam logic [2:0] LAST_PHASE_BYTE   = 3'd3;
  localparam logic [2:0] LAST_PHASE_NIBBLE = 3'd6;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] column;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic       read_write;
    logic       enable_pin;
    logic [7:0] data_bus;
    logic       last_phase;
  } out_item_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
  } xfer_t;

  typedef struct packed {
    logic        nibble_mode;
    logic [15:0] hold;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h10;
      default: off = 8'h50;
    endcase
    return off;
  endfunction

  function automatic out_item_t phase_beat(input logic nibble, input logic [2:0] phase,
                                           input logic rs, input logic [7:0] data,
                                           input logic [7:0] held);
    out_item_t  b;
    logic [7:0] hi;
    logic [7:0] lo;
    hi = (data & HI_MASK) >> 4;
    lo = data & LO_MASK;
    b.reg_select = rs;
    b.read_write = 1'b0;
    if (nibble) begin
      b.enable_pin = (phase == 3'd1) || (phase == 3'd2) || (phase == 3'd4) ||
                     (phase == 3'd5);
      if (phase < 3'd2) begin
        b.data_bus = held & LO_MASK;
      end else if (phase < 3'd5) begin
        b.data_bus = hi;
      end else begin
        b.data_bus = lo;
      end
      b.last_phase = (phase == LAST_PHASE_NIBBLE);
    end else begin
      b.enable_pin = (phase == 3'd1) || (phase == 3'd2);
      b.data_bus   = (phase < 3'd2) ? held : data;
      b.last_phase = (phase == LAST_PHASE_BYTE);
    end
    return b;
  endfunction

endpackage

// ===== src/clpw_front.sv =====
// ----------------------------------------------------------------------------
// clpw_front
// accepts items, drops unused codes, forms the bus byte and rs level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clpw_front #(
  parameter int unsigned ROW_COUNT = clpw_pkg::ROW_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  clpw_pkg::in_item_t in_item_i,
  output logic               push_o,
  output clpw_pkg::xfer_t    push_data_o,
  input  clpw_pkg::q_status_t q_status_i
);
  import clpw_pkg::*;

  localparam logic [2:0] RowCnt = 3'(ROW_COUNT);
  localparam logic [1:0] RowMax = 2'(ROW_COUNT - 1);

  logic       fe_valid_q, fe_valid_d;
  xfer_t      fe_q, fe_d;
  logic       accept;
  logic [1:0] row_sat;
  logic [7:0] addr;

  assign in_ready_o = !fe_valid_q || !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    row_sat = ({1'b0, in_item_i.row} >= RowCnt) ? RowMax : in_item_i.row;
    addr    = ((8'(in_item_i.column) + row_offset(row_sat)) & ADDR_MASK) | CURSOR_SET;
    fe_d    = fe_q;
    case (in_item_i.command)
      CMD_CURSOR: begin
        fe_d.rs   = 1'b0;
        fe_d.data = addr;
      end
      CMD_DATA: begin
        fe_d.rs   = 1'b1;
        fe_d.data = in_item_i.byte_value;
      end
      default: begin
        fe_d.rs   = 1'b0;
        fe_d.data = in_item_i.byte_value;
      end
    endcase
    fe_valid_d = fe_valid_q && q_status_i.full;
    if (accept && (in_item_i.command != CMD_NONE)) begin
      fe_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
    end else begin
      fe_valid_q <= fe_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fe_q <= fe_d;
    end
  end

  assign push_o      = fe_valid_q;
  assign push_data_o = fe_q;

endmodule

// ===== src/clpw_fifo.sv =====
// ----------------------------------------------------------------------------
// clpw_fifo
// short transfer queue between the front and the bus sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clpw_fifo #(
  parameter int unsigned DEPTH = clpw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  clpw_pkg::xfer_t     push_data_i,
  input  logic                pop_i,
  output clpw_pkg::xfer_t     pop_data_o,
  output clpw_pkg::q_status_t status_o
);
  import clpw_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  xfer_t           mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.full  = (cnt_q == CntFull);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_data_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/clpw_back.sv =====
// ----------------------------------------------------------------------------
// clpw_back
// bus phase sequencer with hold timer and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clpw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clpw_pkg::cfg_t      cfg_i,
  input  clpw_pkg::xfer_t     q_data_i,
  input  clpw_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output clpw_pkg::out_item_t out_item_o
);
  import clpw_pkg::*;

  logic        busy_q, busy_d;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  xfer_t       cur_q;
  out_item_t   out_q;
  out_item_t   beat;
  logic        load, gen;
  logic [2:0]  last_idx;
  logic [15:0] hold_m1;

  assign last_idx = cfg_i.nibble_mode ? LAST_PHASE_NIBBLE : LAST_PHASE_BYTE;
  assign hold_m1  = (cfg_i.hold == '0) ? '0 : cfg_i.hold - 16'd1;
  assign load     = !busy_q && !q_status_i.empty && (cnt_q == '0);
  assign gen      = busy_q && (cnt_q == '0) && (!out_valid_q || out_ready_i);
  assign beat     = phase_beat(cfg_i.nibble_mode, phase_q, cur_q.rs, cur_q.data, held_q);
  assign pop_o    = load;

  always_comb begin
    busy_d      = busy_q;
    phase_d     = phase_q;
    held_d      = held_q;
    cnt_d       = (cnt_q != '0) ? cnt_q - 16'd1 : cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      busy_d  = 1'b1;
      phase_d = '0;
    end
    if (gen) begin
      out_valid_d = 1'b1;
      cnt_d       = hold_m1;
      if (phase_q == last_idx) begin
        busy_d = 1'b0;
        held_d = cfg_i.nibble_mode ? (cur_q.data & LO_MASK) : cur_q.data;
      end else begin
        phase_d = phase_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= '0;
      held_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= q_data_i;
    end
    if (gen) begin
      out_q <= beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/char_lcd_parallel_write.sv =====
// path: an accepted item passes the front register, the queue and the sequencer transfer
//   register before its first bus phase beat (of 4 in 8-bit mode, 7 in nibble mode) is registered
// pace: set by the phase hold timer in the sequencer; beats stall while out_ready_i is low
// the queue lets new items be taken while a transfer is still on the bus
// reset: asynchronous, active low; clears control state and held bus levels, config to defaults
// ----------------------------------------------------------------------------
// char_lcd_parallel_write
// write side of a character lcd parallel bus, one beat per bus phase
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module char_lcd_parallel_write #(
  parameter int unsigned ROW_COUNT   = clpw_pkg::ROW_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = clpw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  clpw_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output clpw_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [clpw_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [15:0]                          cfg_data_i
);
  import clpw_pkg::*;

  cfg_t      cfg_q;
  logic      push;
  xfer_t     push_data;
  xfer_t     q_data;
  logic      pop;
  q_status_t q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nibble_mode <= 1'b0;
      cfg_q.hold        <= HOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NIBBLE_MODE: cfg_q.nibble_mode <= cfg_data_i[0];
        CFG_PHASE_HOLD:  cfg_q.hold        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  clpw_front #(
    .ROW_COUNT(ROW_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_status_i  (q_status)
  );

  clpw_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (q_data),
    .status_o    (q_status)
  );

  clpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_data_i    (q_data),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`include "char_lcd_parallel_write_assert.svh"

  `CLPW_ASSERT_IMP(a_q_full_empty, 1'b1, !(q_status.full && q_status.empty), "queue full and empty")
  `CLPW_ASSERT_IMP(a_last_e_low, out_valid_o && out_item_o.last_phase, !out_item_o.enable_pin, "e high on last phase")
  `CLPW_ASSERT_IMP(a_rw_low, out_valid_o, !out_item_o.read_write, "rw driven high")
  `CLPW_ASSERT_NXT(a_pop_fills, pop, !q_status.full, "queue still full after pop")

endmodule
